/* sv/bsps_pkg.sv */
package bsps_pkg;

  // Default sizes of the slot table
  localparam int unsigned MAX_SLOTS_DEF     = 128;
  localparam int unsigned PRIORITY_BITS_DEF = 4;
  localparam int unsigned TRIES_BITS_DEF    = 4;

  // Fixed field widths
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KIND_W   = 3;

  // Config port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_ENTRY_COUNT = '0;

  // Priority given to a slot marked active
  localparam int unsigned ACTIVE_PRIORITY = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 3'd0,
    ACT_RESTART = 3'd1,
    ACT_NEXT    = 3'd2,
    ACT_UPD_CUR = 3'd3,
    ACT_UPD_IDX = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRY     = 3'd0,
    KIND_BAD     = 3'd1,
    KIND_ACTIVE  = 3'd2,
    KIND_INVALID = 3'd3
  } kind_e;

endpackage

/* sv/boot_slot_priority_selector.sv */
// Boot slot priority selector: slot table in a RAM, walked by one compare unit.
// Load, restart and unknown actions go straight to the result; reads and updates
// first take one RAM read (an update with no current slot does not); next slot walks
// the entries in use (entry_count capped at MAX_SLOTS), one entry per cycle.
// One item at a time: ready returns once the result sits in the output register.
// Reset (rst_ni low, asynchronous) clears search state and entry_count; table is unset.
module boot_slot_priority_selector
  import bsps_pkg::*;
#(
  parameter int unsigned MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int unsigned TRIES_BITS    = TRIES_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACTION_W-1:0]      action_i,
  input  logic [IDX_W-1:0]         slot_index_i,
  input  logic                     in_bootable_i,
  input  logic [PRIORITY_BITS-1:0] in_priority_i,
  input  logic [TRIES_BITS-1:0]    in_tries_i,
  input  logic                     in_successful_i,
  input  logic [KIND_W-1:0]        update_kind_i,
  // Output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     status_o,
  output logic                     found_o,
  output logic [IDX_W-1:0]         out_index_o,
  output logic [PRIORITY_BITS-1:0] out_priority_o,
  output logic [TRIES_BITS-1:0]    out_tries_o,
  output logic                     out_successful_o,
  output logic                     table_changed_o
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned LW = PRIORITY_BITS + 1;

  typedef struct packed {
    logic                     bootable;
    logic [PRIORITY_BITS-1:0] priority_;
    logic [TRIES_BITS-1:0]    tries;
    logic                     successful;
  } slot_t;

  typedef struct packed {
    slot_t ent;
    logic  err;
    logic  chg;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_FIN
  } state_e;

  // Apply one update kind to a slot entry
  function automatic upd_t apply_upd(slot_t e, kind_e k);
    upd_t r;
    r.ent = e;
    r.err = 1'b0;
    r.chg = 1'b0;
    if (!e.bootable) begin
      r.err = 1'b1;
    end else begin
      unique case (k)
        KIND_TRY: begin
          if (!e.successful) begin
            r.chg = 1'b1;
            if (e.tries > TRIES_BITS'(1)) begin
              r.ent.tries = e.tries - TRIES_BITS'(1);
            end else begin
              r.ent.tries     = '0;
              r.ent.priority_ = '0;
            end
          end
        end
        KIND_BAD: begin
          if (!e.successful) begin
            r.chg           = 1'b1;
            r.ent.tries     = '0;
            r.ent.priority_ = '0;
          end
        end
        KIND_ACTIVE: begin
          r.chg            = 1'b1;
          r.ent.tries      = '0;
          r.ent.priority_  = PRIORITY_BITS'(ACTIVE_PRIORITY);
          r.ent.successful = 1'b1;
        end
        KIND_INVALID: begin
          r.chg            = 1'b1;
          r.ent.tries      = '0;
          r.ent.priority_  = '0;
          r.ent.successful = 1'b0;
        end
        default: r.err = 1'b1;
      endcase
    end
    return r;
  endfunction

  function automatic logic qualifies(slot_t e);
    return e.bootable && (e.successful || (e.tries != '0));
  endfunction

  // Slot table RAM
  slot_t           mem_q [MAX_SLOTS];
  slot_t           mem_rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [AW-1:0]   mem_ra;
  slot_t           mem_wd;

  // Control and search state
  state_e                   state_q, state_d;
  logic [COUNT_W-1:0]       entry_count_q;
  logic                     cur_valid_q, cur_valid_d;
  logic [AW-1:0]            cur_slot_q, cur_slot_d;
  logic [LW-1:0]            cur_level_q, cur_level_d;
  logic                     changed_q, changed_d;
  action_e                  act_q, act_d;
  kind_e                    kind_q, kind_d;
  logic [AW-1:0]            tgt_q, tgt_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic                     cmp_valid_q, cmp_valid_d;
  logic [AW-1:0]            cmp_idx_q, cmp_idx_d;
  logic                     have_q, have_d;
  logic [AW-1:0]            best_idx_q, best_idx_d;
  logic [PRIORITY_BITS-1:0] best_prio_q, best_prio_d;
  slot_t                    best_ent_q, best_ent_d;

  // Pending result
  logic                     res_status_q, res_status_d;
  logic                     res_found_q, res_found_d;
  logic [IDX_W-1:0]         res_index_q, res_index_d;
  slot_t                    res_ent_q, res_ent_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic                     out_status_q, out_status_d;
  logic                     out_found_q, out_found_d;
  logic [IDX_W-1:0]         out_index_q, out_index_d;
  slot_t                    out_ent_q, out_ent_d;
  logic                     out_changed_q, out_changed_d;

  logic                     cfg_wr;
  logic [CW-1:0]            used_n;
  logic [AW-1:0]            slot_addr;
  logic                     slot_oor;
  logic                     issue;
  upd_t                     upd;
  slot_t                    load_ent;

  // Config register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[APB_AW-1:2] == REG_ENTRY_COUNT) ? APB_DW'(entry_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_wr) begin
      entry_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // Entries in use, capped at table size
  assign used_n = (32'(entry_count_q) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(entry_count_q);

  assign slot_addr = AW'(slot_index_i);
  assign slot_oor  = 32'(slot_index_i) >= 32'(MAX_SLOTS);
  assign issue     = ptr_q < used_n;
  assign upd       = apply_upd(mem_rd_q, kind_q);

  assign load_ent.bootable   = in_bootable_i;
  assign load_ent.priority_  = in_priority_i;
  assign load_ent.tries      = in_tries_i;
  assign load_ent.successful = in_successful_i;

  // RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    cur_valid_d  = cur_valid_q;
    cur_slot_d   = cur_slot_q;
    cur_level_d  = cur_level_q;
    changed_d    = changed_q;
    act_d        = act_q;
    kind_d       = kind_q;
    tgt_d        = tgt_q;
    ptr_d        = ptr_q;
    cmp_valid_d  = cmp_valid_q;
    cmp_idx_d    = cmp_idx_q;
    have_d       = have_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_ent_d   = best_ent_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_index_d  = res_index_q;
    res_ent_d    = res_ent_q;
    out_status_d  = out_status_q;
    out_found_d   = out_found_q;
    out_index_d   = out_index_q;
    out_ent_d     = out_ent_q;
    out_changed_d = out_changed_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    mem_we = 1'b0;
    mem_wa = tgt_q;
    mem_wd = upd.ent;
    mem_ra = tgt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d        = action_e'(action_i);
          kind_d       = kind_e'(update_kind_i);
          res_status_d = 1'b0;
          res_found_d  = 1'b0;
          res_index_d  = '0;
          res_ent_d    = '0;
          state_d      = ST_FIN;
          unique case (action_e'(action_i))
            ACT_LOAD: begin
              res_index_d = slot_index_i;
              if (slot_oor) begin
                res_status_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = slot_addr;
                mem_wd    = load_ent;
                res_ent_d = load_ent;
              end
            end
            ACT_READ, ACT_UPD_IDX: begin
              res_index_d = slot_index_i;
              if (slot_oor) begin
                res_status_d = 1'b1;
              end else begin
                tgt_d   = slot_addr;
                mem_ra  = slot_addr;
                state_d = ST_UPD;
              end
            end
            ACT_UPD_CUR: begin
              if (!cur_valid_q) begin
                res_status_d = 1'b1;
              end else begin
                tgt_d       = cur_slot_q;
                mem_ra      = cur_slot_q;
                res_index_d = IDX_W'(cur_slot_q);
                state_d     = ST_UPD;
              end
            end
            ACT_RESTART: begin
              cur_valid_d = 1'b0;
              cur_slot_d  = '0;
              cur_level_d = {1'b1, {PRIORITY_BITS{1'b0}}};
              changed_d   = 1'b0;
            end
            ACT_NEXT: begin
              have_d      = 1'b0;
              best_idx_d  = '0;
              best_prio_d = '0;
              best_ent_d  = '0;
              cmp_valid_d = 1'b0;
              if (cur_valid_q) begin
                ptr_d   = CW'(cur_slot_q) + CW'(1);
                state_d = ST_SCAN_A;
              end else begin
                ptr_d   = '0;
                state_d = ST_SCAN_B;
              end
            end
            default: res_status_d = 1'b1;
          endcase
        end
      end

      // Read back or update one slot from the RAM word
      ST_UPD: begin
        if (act_q == ACT_READ) begin
          res_ent_d = mem_rd_q;
        end else begin
          mem_we       = 1'b1;
          res_ent_d    = upd.ent;
          res_status_d = upd.err;
          changed_d    = changed_q | upd.chg;
        end
        state_d = ST_FIN;
      end

      // Later slot at the current level
      ST_SCAN_A: begin
        mem_ra      = ptr_q[AW-1:0];
        cmp_valid_d = issue;
        cmp_idx_d   = ptr_q[AW-1:0];
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (cmp_valid_q && qualifies(mem_rd_q) &&
            ({1'b0, mem_rd_q.priority_} == cur_level_q)) begin
          cur_slot_d  = cmp_idx_q;
          res_found_d = 1'b1;
          res_index_d = IDX_W'(cmp_idx_q);
          res_ent_d   = mem_rd_q;
          state_d     = ST_FIN;
        end else if (!cmp_valid_q && !issue) begin
          ptr_d       = '0;
          cmp_valid_d = 1'b0;
          state_d     = ST_SCAN_B;
        end
      end

      // First slot with the highest priority below the current level
      ST_SCAN_B: begin
        mem_ra      = ptr_q[AW-1:0];
        cmp_valid_d = issue;
        cmp_idx_d   = ptr_q[AW-1:0];
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (cmp_valid_q && qualifies(mem_rd_q) &&
            ({1'b0, mem_rd_q.priority_} < cur_level_q) &&
            (mem_rd_q.priority_ > best_prio_q)) begin
          have_d      = 1'b1;
          best_idx_d  = cmp_idx_q;
          best_prio_d = mem_rd_q.priority_;
          best_ent_d  = mem_rd_q;
        end
        if (!cmp_valid_q && !issue) begin
          cur_valid_d = have_q;
          cur_slot_d  = have_q ? best_idx_q : '0;
          cur_level_d = {1'b0, best_prio_q};
          res_found_d = have_q;
          res_index_d = have_q ? IDX_W'(best_idx_q) : '0;
          res_ent_d   = have_q ? best_ent_q : '0;
          state_d     = ST_FIN;
        end
      end

      // Move result into the output register once it is free
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_found_d   = res_found_q;
          out_index_d   = res_index_q;
          out_ent_d     = res_ent_q;
          out_changed_d = changed_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cur_valid_q   <= 1'b0;
      cur_slot_q    <= '0;
      cur_level_q   <= {1'b1, {PRIORITY_BITS{1'b0}}};
      changed_q     <= 1'b0;
      ptr_q         <= '0;
      cmp_valid_q   <= 1'b0;
      have_q        <= 1'b0;
      act_q         <= ACT_LOAD;
      kind_q        <= KIND_TRY;
      tgt_q         <= '0;
      cmp_idx_q     <= '0;
      best_idx_q    <= '0;
      best_prio_q   <= '0;
      best_ent_q    <= '0;
      res_status_q  <= 1'b0;
      res_found_q   <= 1'b0;
      res_index_q   <= '0;
      res_ent_q     <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= 1'b0;
      out_found_q   <= 1'b0;
      out_index_q   <= '0;
      out_ent_q     <= '0;
      out_changed_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cur_valid_q   <= cur_valid_d;
      cur_slot_q    <= cur_slot_d;
      cur_level_q   <= cur_level_d;
      changed_q     <= changed_d;
      ptr_q         <= ptr_d;
      cmp_valid_q   <= cmp_valid_d;
      have_q        <= have_d;
      act_q         <= act_d;
      kind_q        <= kind_d;
      tgt_q         <= tgt_d;
      cmp_idx_q     <= cmp_idx_d;
      best_idx_q    <= best_idx_d;
      best_prio_q   <= best_prio_d;
      best_ent_q    <= best_ent_d;
      res_status_q  <= res_status_d;
      res_found_q   <= res_found_d;
      res_index_q   <= res_index_d;
      res_ent_q     <= res_ent_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_found_q   <= out_found_d;
      out_index_q   <= out_index_d;
      out_ent_q     <= out_ent_d;
      out_changed_q <= out_changed_d;
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_o          = out_found_q;
  assign out_index_o      = out_index_q;
  assign out_priority_o   = out_ent_q.priority_;
  assign out_tries_o      = out_ent_q.tries;
  assign out_successful_o = out_ent_q.successful;
  assign table_changed_o  = out_changed_q;

endmodule

/* sv/bsps_checker.sv */
module bsps_checker
  import bsps_pkg::*;
#(
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int unsigned TRIES_BITS    = TRIES_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     status_o,
  input logic                     found_o,
  input logic [IDX_W-1:0]         out_index_o,
  input logic [PRIORITY_BITS-1:0] out_priority_o,
  input logic [TRIES_BITS-1:0]    out_tries_o,
  input logic                     out_successful_o
);

  // The block is not ready in the cycle after it takes a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item still in work");

  // A found slot is never reported with an error
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !status_o)
    else $error("found slot reported with error status");

  // A chosen slot has a nonzero priority
  a_found_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (out_priority_o != '0))
    else $error("chosen slot has priority zero");

  // A chosen slot is successful or has tries left
  a_found_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (out_successful_o || (out_tries_o != '0)))
    else $error("chosen slot has no tries and no success");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_index_o))
    else $error("stalled result changed");

endmodule

bind boot_slot_priority_selector bsps_checker #(
  .PRIORITY_BITS(PRIORITY_BITS),
  .TRIES_BITS   (TRIES_BITS)
) u_bsps_checker (.*);

/* bench/tb_boot_slot_priority_selector.sv */
module tb_boot_slot_priority_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import bsps_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [ACTION_W-1:0] ACT_UNUSED_6      = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_7      = 3'd7;
  localparam logic [KIND_W-1:0]   KIND_UNUSED_FIRST = 3'd4;
  localparam logic [KIND_W-1:0]   KIND_UNUSED_LAST  = 3'd7;

  localparam logic [APB_AW-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};
  localparam int unsigned       PB               = PRIORITY_BITS_DEF;
  localparam int unsigned       TB               = TRIES_BITS_DEF;
  localparam int unsigned       LEVEL_TOP        = 1 << PB;
  // Longest search is two passes over the table
  localparam int unsigned       SEARCH_CYCLES    = 2 * MAX_SLOTS_DEF + 10;
  localparam int unsigned       WATCHDOG_LIMIT   = 3000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    slot;
    logic                bootable;
    logic [PB-1:0]       prio;
    logic [TB-1:0]       tries;
    logic                successful;
    logic [KIND_W-1:0]   kind;
  } slot_req_t;

  typedef struct packed {
    logic          status;
    logic          found;
    logic [IDX_W-1:0] index;
    logic [PB-1:0] prio;
    logic [TB-1:0] tries;
    logic          successful;
    logic          changed;
  } slot_resp_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_JITTER, RX_LONG_STALLS, RX_TOGGLE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic                in_valid_i;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i;
  logic [IDX_W-1:0]    slot_index_i;
  logic                in_bootable_i;
  logic [PB-1:0]       in_priority_i;
  logic [TB-1:0]       in_tries_i;
  logic                in_successful_i;
  logic [KIND_W-1:0]   update_kind_i;

  logic                out_valid_o;
  logic                out_ready_i;
  logic                status_o;
  logic                found_o;
  logic [IDX_W-1:0]    out_index_o;
  logic [PB-1:0]       out_priority_o;
  logic [TB-1:0]       out_tries_o;
  logic                out_successful_o;
  logic                table_changed_o;

  boot_slot_priority_selector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .slot_index_i     (slot_index_i),
    .in_bootable_i    (in_bootable_i),
    .in_priority_i    (in_priority_i),
    .in_tries_i       (in_tries_i),
    .in_successful_i  (in_successful_i),
    .update_kind_i    (update_kind_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_o          (found_o),
    .out_index_o      (out_index_o),
    .out_priority_o   (out_priority_o),
    .out_tries_o      (out_tries_o),
    .out_successful_o (out_successful_o),
    .table_changed_o  (table_changed_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the slot table and search state
  bit          tbl_bootable   [MAX_SLOTS_DEF];
  bit [PB-1:0] tbl_priority   [MAX_SLOTS_DEF];
  bit [TB-1:0] tbl_tries      [MAX_SLOTS_DEF];
  bit          tbl_successful [MAX_SLOTS_DEF];
  bit          sel_valid;
  int unsigned sel_slot;
  int unsigned sel_level;
  bit          sel_changed;
  int unsigned cfg_entry_count;

  // Slots written so far; the table is undefined elsewhere
  bit          slot_loaded [MAX_SLOTS_DEF];
  int unsigned loaded_slots[$];

  slot_resp_t  pending_results[$];
  slot_resp_t  head_result;
  int unsigned mismatches;
  int unsigned idle_cycles;

  bit          sender_gaps;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_stall_left;

  function automatic int unsigned used_entries();
    return (cfg_entry_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cfg_entry_count;
  endfunction

  function automatic bit slot_qualifies(int unsigned i);
    return tbl_bootable[i] && (tbl_successful[i] || tbl_tries[i] != 0);
  endfunction

  function automatic slot_resp_t slot_report(int unsigned i);
    slot_resp_t rs;
    rs            = '0;
    rs.index      = i[IDX_W-1:0];
    rs.prio       = tbl_priority[i];
    rs.tries      = tbl_tries[i];
    rs.successful = tbl_successful[i];
    return rs;
  endfunction

  // Returns the error status of an update on slot i
  function automatic bit apply_slot_update(int unsigned i, logic [KIND_W-1:0] kind);
    if (!tbl_bootable[i]) return 1'b1;
    case (kind)
      KIND_TRY: begin
        // successful slots keep their tries
        if (tbl_successful[i]) return 1'b0;
        if (tbl_tries[i] > 1) begin
          tbl_tries[i] = tbl_tries[i] - TB'(1);
        end else begin
          // last try used up: same as bad
          tbl_tries[i]    = '0;
          tbl_priority[i] = '0;
        end
        sel_changed = 1'b1;
      end
      KIND_BAD: begin
        if (!tbl_successful[i]) begin
          tbl_tries[i]    = '0;
          tbl_priority[i] = '0;
          sel_changed     = 1'b1;
        end
      end
      KIND_ACTIVE: begin
        tbl_tries[i]      = '0;
        tbl_priority[i]   = ACTIVE_PRIORITY[PB-1:0];
        tbl_successful[i] = 1'b1;
        sel_changed       = 1'b1;
      end
      KIND_INVALID: begin
        tbl_tries[i]      = '0;
        tbl_priority[i]   = '0;
        tbl_successful[i] = 1'b0;
        sel_changed       = 1'b1;
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  // Same level after the current slot first, then best level below it
  function automatic bit search_next_slot();
    int unsigned n;
    int unsigned i;
    int unsigned best;
    int unsigned best_prio;
    bit          have;
    n         = used_entries();
    best      = 0;
    best_prio = 0;
    have      = 1'b0;
    if (sel_valid) begin
      for (i = sel_slot + 1; i < n; i++) begin
        if (slot_qualifies(i) && tbl_priority[i] == sel_level) begin
          sel_slot = i;
          return 1'b1;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      if (slot_qualifies(i) && tbl_priority[i] < sel_level && tbl_priority[i] > best_prio) begin
        best      = i;
        best_prio = 32'(tbl_priority[i]);
        have      = 1'b1;
      end
    end
    // nothing found parks the level at zero until a restart
    sel_valid = have;
    sel_slot  = have ? best : 0;
    sel_level = best_prio;
    return have;
  endfunction

  // Expected result of one transaction, updating the shadow state
  function automatic slot_resp_t predict_selection(slot_req_t rq);
    slot_resp_t rs;
    bit         st;
    rs = '0;
    st = 1'b0;
    case (rq.action)
      // a 7-bit index never leaves the 128-entry table
      ACT_LOAD, ACT_UPD_IDX, ACT_READ: begin
        if (rq.action == ACT_LOAD) begin
          tbl_bootable[rq.slot]   = rq.bootable;
          tbl_priority[rq.slot]   = rq.prio;
          tbl_tries[rq.slot]      = rq.tries;
          tbl_successful[rq.slot] = rq.successful;
        end else if (rq.action == ACT_UPD_IDX) begin
          st = apply_slot_update(rq.slot, rq.kind);
        end
        rs = slot_report(rq.slot);
      end
      ACT_RESTART: begin
        sel_valid   = 1'b0;
        sel_slot    = 0;
        sel_level   = LEVEL_TOP;
        sel_changed = 1'b0;
      end
      ACT_NEXT: begin
        if (search_next_slot()) begin
          rs       = slot_report(sel_slot);
          rs.found = 1'b1;
        end
      end
      ACT_UPD_CUR: begin
        if (!sel_valid) begin
          st = 1'b1;
        end else begin
          st = apply_slot_update(sel_slot, rq.kind);
          rs = slot_report(sel_slot);
        end
      end
      default: st = 1'b1;
    endcase
    rs.status  = st;
    rs.changed = sel_changed;
    return rs;
  endfunction

  function automatic slot_req_t slot_request(logic [ACTION_W-1:0] act, int unsigned slot,
                                             bit boot, int unsigned prio, int unsigned tries,
                                             bit succ, logic [KIND_W-1:0] kind);
    slot_req_t rq;
    rq.action     = act;
    rq.slot       = slot[IDX_W-1:0];
    rq.bootable   = boot;
    rq.prio       = prio[PB-1:0];
    rq.tries      = tries[TB-1:0];
    rq.successful = succ;
    rq.kind       = kind;
    return rq;
  endfunction

  // Random transaction that never touches an unwritten slot
  function automatic slot_req_t pick_random_request();
    slot_req_t   rq;
    int unsigned n;
    int unsigned r;
    int unsigned k;
    n             = used_entries();
    rq.bootable   = ($urandom_range(0, 6) != 0);
    // few distinct levels so ties and same-level continuation happen
    rq.prio       = PB'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) :
                                                      $urandom_range(1, 4));
    rq.tries      = TB'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) :
                                                      $urandom_range(0, 3));
    rq.successful = ($urandom_range(0, 2) == 0);
    rq.kind       = KIND_W'(($urandom_range(0, 4) == 0) ?
                            $urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST) :
                            $urandom_range(KIND_TRY, KIND_INVALID));
    rq.slot       = IDX_W'($urandom_range(0, MAX_SLOTS_DEF - 1));
    r             = $urandom_range(0, 99);
    if (r < 22) begin
      rq.action = ACT_LOAD;
      if (n > 0 && $urandom_range(0, 3) != 0) rq.slot = IDX_W'($urandom_range(0, n - 1));
    end else if (r < 30) begin
      rq.action = ACT_RESTART;
    end else if (r < 58) begin
      rq.action = ACT_NEXT;
    end else if (r < 76) begin
      rq.action = ACT_UPD_CUR;
    end else if (r < 86) begin
      rq.action = ACT_UPD_IDX;
    end else if (r < 97) begin
      rq.action = ACT_READ;
    end else begin
      rq.action = $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
    end
    // indexed access only to written slots
    if (rq.action == ACT_READ || rq.action == ACT_UPD_IDX) begin
      if (loaded_slots.size() == 0) rq.action = ACT_LOAD;
      else if (!slot_loaded[rq.slot])
        rq.slot = IDX_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
    end
    // a search walks every used entry: fill any hole first
    if (rq.action == ACT_NEXT) begin
      for (k = 0; k < n; k++) begin
        if (!slot_loaded[k]) begin
          rq.action = ACT_LOAD;
          rq.slot   = k[IDX_W-1:0];
          break;
        end
      end
    end
    return rq;
  endfunction

  // Drive one transaction, record its expected result, then maybe idle
  task automatic send_item(slot_req_t rq);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    action_i        <= rq.action;
    slot_index_i    <= rq.slot;
    in_bootable_i   <= rq.bootable;
    in_priority_i   <= rq.prio;
    in_tries_i      <= rq.tries;
    in_successful_i <= rq.successful;
    update_kind_i   <= rq.kind;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_selection(rq));
    if (rq.action == ACT_LOAD && !slot_loaded[rq.slot]) begin
      slot_loaded[rq.slot] = 1'b1;
      loaded_slots.push_back(32'(rq.slot));
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (sender_gaps)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Stop sending and let every expected result come out
  task automatic drain_results(int unsigned settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register write while idle, then read it back
  task automatic write_entry_count(int unsigned value);
    drain_results(4);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRY_COUNT_ADDR;
    pwdata  <= APB_DW'(value[COUNT_W-1:0]);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_entry_count = 32'(value[COUNT_W-1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[COUNT_W-1:0] !== value[COUNT_W-1:0]) begin
      $error("entry_count readback: expected %0d, got %0d", value[COUNT_W-1:0],
             prdata[COUNT_W-1:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_phase(int unsigned count, int unsigned items);
    write_entry_count(count);
    sender_gaps = ($urandom_range(0, 3) != 0);
    repeat (items) send_item(pick_random_request());
  endtask

  // Empty table after reset: searches find nothing, bad actions rejected
  task automatic test_empty_table();
    sender_gaps = 1'b1;
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_UPD_CUR, 0, 0, 0, 0, 0, KIND_ACTIVE));
    send_item(slot_request(ACT_UNUSED_6, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_UNUSED_7, 127, 1, 15, 15, 1, KIND_UNUSED_LAST));
    send_item(slot_request(ACT_RESTART, 0, 0, 0, 0, 0, KIND_TRY));
  endtask

  // Hand-built table walking every search rule and update kind
  task automatic test_directed_selection();
    write_entry_count(6);
    send_item(slot_request(ACT_LOAD, 0, 1, 5, 3, 0, KIND_TRY));
    send_item(slot_request(ACT_LOAD, 1, 1, 5, 0, 1, KIND_TRY));
    // no tries, not successful: does not qualify
    send_item(slot_request(ACT_LOAD, 2, 1, 15, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_LOAD, 3, 0, 15, 15, 1, KIND_TRY));
    send_item(slot_request(ACT_LOAD, 4, 1, 1, 1, 0, KIND_TRY));
    send_item(slot_request(ACT_LOAD, 5, 1, 0, 15, 1, KIND_TRY));
    send_item(slot_request(ACT_LOAD, 127, 1, 15, 15, 1, KIND_TRY));
    send_item(slot_request(ACT_READ, 127, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_RESTART, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_UPD_CUR, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    // try and bad leave a successful slot alone
    send_item(slot_request(ACT_UPD_CUR, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_UPD_CUR, 0, 0, 0, 0, 0, KIND_BAD));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    // single try left: acts as bad
    send_item(slot_request(ACT_UPD_CUR, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_UPD_CUR, 0, 0, 0, 0, 0, KIND_BAD));
    send_item(slot_request(ACT_RESTART, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_UPD_IDX, 3, 0, 0, 0, 0, KIND_ACTIVE));
    send_item(slot_request(ACT_UPD_IDX, 0, 0, 0, 0, 0, KIND_UNUSED_FIRST));
    send_item(slot_request(ACT_UPD_IDX, 2, 0, 0, 0, 0, KIND_ACTIVE));
    send_item(slot_request(ACT_UPD_IDX, 5, 0, 0, 0, 0, KIND_INVALID));
    send_item(slot_request(ACT_UPD_IDX, 0, 0, 0, 0, 0, KIND_BAD));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
    send_item(slot_request(ACT_NEXT, 0, 0, 0, 0, 0, KIND_TRY));
  endtask

  // Random traffic on small tables
  task automatic test_small_tables();
    run_random_phase(1, 180);
    run_random_phase(3, 180);
    run_random_phase(8, 180);
    run_random_phase(16, 180);
    run_random_phase(2, 180);
  endtask

  // Whole table written, then entry counts at and above the table size
  task automatic test_full_table();
    int unsigned i;
    slot_req_t   rq;
    sender_gaps = 1'b1;
    for (i = 0; i < MAX_SLOTS_DEF; i++) begin
      rq        = pick_random_request();
      rq.action = ACT_LOAD;
      rq.slot   = i[IDX_W-1:0];
      send_item(rq);
    end
    run_random_phase(MAX_SLOTS_DEF, 150);
    run_random_phase(255, 150);
    run_random_phase(200, 100);
  endtask

  // Table shrunk back down, down to no entries at all
  task automatic test_shrunk_table();
    run_random_phase(5, 150);
    run_random_phase(0, 50);
  endtask

  // Receiver: stall pattern that changes mode on its own
  always @(negedge clk_i) begin
    if (rx_stall_left != 0) begin
      out_ready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      case (rx_mode)
        RX_JITTER:      if ($urandom_range(0, 3) == 0) rx_stall_left = $urandom_range(1, 3);
        RX_LONG_STALLS: if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(5, 30);
        RX_TOGGLE:      rx_stall_left = $urandom_range(0, 1);
        default: ;
      endcase
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 300);
    end else begin
      rx_mode_left--;
    end
  end

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: out_index %0d", out_index_o);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", 8'(head_result.status), 8'(status_o));
        check_field("found", 8'(head_result.found), 8'(found_o));
        check_field("out_index", 8'(head_result.index), 8'(out_index_o));
        check_field("out_priority", 8'(head_result.prio), 8'(out_priority_o));
        check_field("out_tries", 8'(head_result.tries), 8'(out_tries_o));
        check_field("out_successful", 8'(head_result.successful), 8'(out_successful_o));
        check_field("table_changed", 8'(head_result.changed), 8'(table_changed_o));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_LOAD;
    slot_index_i    = '0;
    in_bootable_i   = 1'b0;
    in_priority_i   = '0;
    in_tries_i      = '0;
    in_successful_i = 1'b0;
    update_kind_i   = KIND_TRY;
    out_ready_i     = 1'b0;
    sel_valid       = 1'b0;
    sel_slot        = 0;
    sel_level       = LEVEL_TOP;
    sel_changed     = 1'b0;
    cfg_entry_count = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    sender_gaps     = 1'b1;
    burst_left      = 1;
    rx_mode         = RX_ALWAYS;
    rx_mode_left    = 40;
    rx_stall_left   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_directed_selection();
    test_small_tables();
    test_full_table();
    test_shrunk_table();

    drain_results(SEARCH_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
